@@ design/pkbu_pkg.sv @@
// shared types and constants of the led packet bit unpacker
package pkbu_pkg;

    localparam int HEAD_BITS   = 6;
    localparam int REC_BITS    = 46;
    localparam int WORD_BITS   = 32;
    localparam int BYTE_BITS   = 8;
    localparam int ACC_W       = 53;
    localparam int HELD_W      = 6;
    localparam int REM_W       = 3;
    localparam int LED_W       = 11;
    localparam int COLOUR_W    = 8;
    localparam int ITEM_CNT_W  = 7;
    localparam int SET_ID_W    = 2;

    localparam logic [LED_W-1:0]      LED_COUNT_RESET = 11'd877;
    localparam logic [ITEM_CNT_W-1:0] ITEM_CNT_MAX    = 7'd127;
    localparam logic [SET_ID_W-1:0]   SET_ID_MAX      = 2'd2;

    typedef enum logic [1:0] {
        MODE_FILL    = 2'd0,
        MODE_WORD    = 2'd1,
        MODE_SETTING = 2'd2,
        MODE_NONE    = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        CMD_FILL    = 2'd0,
        CMD_WORD    = 2'd1,
        CMD_SETTING = 2'd2
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind               cmd_kind;
        logic [LED_W-1:0]        range_start;
        logic [LED_W-1:0]        range_end;
        logic [COLOUR_W-1:0]     red;
        logic [COLOUR_W-1:0]     green;
        logic [COLOUR_W-1:0]     blue;
        logic [ITEM_CNT_W-1:0]   word_index;
        logic [WORD_BITS-1:0]    word_value;
        logic [SET_ID_W-1:0]     setting_id;
        logic [WORD_BITS-1:0]    setting_value;
    } t_cmd;

endpackage

@@ design/pkbu_in_if.sv @@
// packet byte channel: valid/ready handshake with byte payload
interface pkbu_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] packet_byte;
    logic       last_of_packet;

    modport source (output valid, output packet_byte, output last_of_packet, input ready);
    modport sink   (input valid, input packet_byte, input last_of_packet, output ready);
endinterface

@@ design/pkbu_out_if.sv @@
// led command channel: valid/ready handshake with command payload
interface pkbu_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cmd_kind;
    logic [10:0] range_start;
    logic [10:0] range_end;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [6:0]  word_index;
    logic [31:0] word_value;
    logic [1:0]  setting_id;
    logic [31:0] setting_value;

    modport source (
        output valid, output cmd_kind, output range_start, output range_end,
        output red, output green, output blue, output word_index, output word_value,
        output setting_id, output setting_value, input ready
    );
    modport sink (
        input valid, input cmd_kind, input range_start, input range_end,
        input red, input green, input blue, input word_index, input word_value,
        input setting_id, input setting_value, output ready
    );
endinterface

@@ design/pkbu_parser.sv @@
// packet parser: bit accumulator, item extraction and command decode
module pkbu_parser #(
    parameter int MAX_PACKET_BYTES = 512
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_take,
    input  logic [7:0]                    i_packet_byte,
    input  logic                          i_last_of_packet,
    input  logic [pkbu_pkg::LED_W-1:0]    i_led_count,
    output logic                          o_fire,
    output pkbu_pkg::t_cmd                o_cmd
);

    localparam int BS_W = $clog2(MAX_PACKET_BYTES + 1);
    localparam logic [BS_W-1:0] BS_MAX = BS_W'(MAX_PACKET_BYTES);

    pkbu_pkg::t_mode                         r_mode, n_mode;
    logic [pkbu_pkg::ACC_W-1:0]              r_acc, n_acc;
    logic [pkbu_pkg::HELD_W-1:0]             r_held, n_held;
    logic [BS_W-1:0]                         r_bytes, n_bytes;
    logic [pkbu_pkg::ITEM_CNT_W-1:0]         r_items, n_items;
    logic [pkbu_pkg::SET_ID_W-1:0]           r_set_id, n_set_id;
    logic                                    r_set_ok, n_set_ok;

    logic [pkbu_pkg::ACC_W-1:0]              acc_sh;
    logic [pkbu_pkg::ACC_W-1:0]              item;
    logic [pkbu_pkg::HELD_W-1:0]             held_sum;
    logic [pkbu_pkg::HELD_W-1:0]             need;
    logic [pkbu_pkg::HELD_W-1:0]             rem_full;
    logic [pkbu_pkg::REM_W-1:0]              rem;
    logic [pkbu_pkg::LED_W-1:0]              fill_start;
    logic [pkbu_pkg::LED_W-1:0]              fill_end_raw;
    logic [pkbu_pkg::LED_W-1:0]              fill_end;
    logic [pkbu_pkg::LED_W-1:0]              led_last;
    logic [pkbu_pkg::ITEM_CNT_W-1:0]         items_inc;
    logic [pkbu_pkg::WORD_BITS-1:0]          word;

    // datapath for one byte
    always_comb begin
        acc_sh       = {r_acc[pkbu_pkg::ACC_W-pkbu_pkg::BYTE_BITS-1:0], i_packet_byte};
        held_sum     = r_held + pkbu_pkg::HELD_W'(pkbu_pkg::BYTE_BITS);
        need         = (r_mode == pkbu_pkg::MODE_FILL) ? pkbu_pkg::HELD_W'(pkbu_pkg::REC_BITS)
                                                       : pkbu_pkg::HELD_W'(pkbu_pkg::WORD_BITS);
        rem_full     = held_sum - need;
        rem          = rem_full[pkbu_pkg::REM_W-1:0];
        // bits above the held count are stale; the slices below never reach them
        item         = acc_sh >> rem;
        word         = item[pkbu_pkg::WORD_BITS-1:0];
        fill_start   = item[45:35];
        fill_end_raw = item[34:24];
        led_last     = i_led_count - pkbu_pkg::LED_W'(1);
        fill_end     = (fill_end_raw > led_last) ? led_last : fill_end_raw;
        items_inc    = (r_items == pkbu_pkg::ITEM_CNT_MAX) ? r_items
                                                           : r_items + pkbu_pkg::ITEM_CNT_W'(1);
    end

    // next state and result
    always_comb begin
        n_mode   = r_mode;
        n_acc    = r_acc;
        n_held   = r_held;
        n_bytes  = r_bytes;
        n_items  = r_items;
        n_set_id = r_set_id;
        n_set_ok = r_set_ok;
        o_fire   = 1'b0;
        o_cmd    = '0;
        if (i_take && (r_bytes < BS_MAX)) begin
            if (r_bytes == '0) begin
                n_mode  = pkbu_pkg::t_mode'(i_packet_byte[7:6]);
                n_acc   = pkbu_pkg::ACC_W'(i_packet_byte[5:0]);
                n_held  = pkbu_pkg::HELD_W'(pkbu_pkg::HEAD_BITS);
                n_bytes = BS_W'(1);
            end else begin
                n_bytes = r_bytes + BS_W'(1);
                if (r_mode != pkbu_pkg::MODE_NONE) begin
                    n_acc = acc_sh;
                    if (held_sum < need) begin
                        n_held = held_sum;
                    end else begin
                        n_held  = pkbu_pkg::HELD_W'(rem);
                        n_items = items_inc;
                        case (r_mode)
                            pkbu_pkg::MODE_FILL: begin
                                if ((i_led_count != '0) && (fill_start <= fill_end)) begin
                                    o_fire            = 1'b1;
                                    o_cmd.cmd_kind    = pkbu_pkg::CMD_FILL;
                                    o_cmd.range_start = fill_start;
                                    o_cmd.range_end   = fill_end;
                                    o_cmd.red         = item[23:16];
                                    o_cmd.green       = item[15:8];
                                    o_cmd.blue        = item[7:0];
                                end
                            end
                            pkbu_pkg::MODE_WORD: begin
                                o_fire           = 1'b1;
                                o_cmd.cmd_kind   = pkbu_pkg::CMD_WORD;
                                o_cmd.word_index = r_items;
                                o_cmd.word_value = word;
                            end
                            pkbu_pkg::MODE_SETTING: begin
                                if (r_items == '0) begin
                                    n_set_id = word[pkbu_pkg::SET_ID_W-1:0];
                                    n_set_ok = (word[pkbu_pkg::WORD_BITS-1:pkbu_pkg::SET_ID_W]
                                                == '0) &&
                                               (word[pkbu_pkg::SET_ID_W-1:0]
                                                <= pkbu_pkg::SET_ID_MAX);
                                end else if ((r_items == pkbu_pkg::ITEM_CNT_W'(1)) && r_set_ok) begin
                                    o_fire              = 1'b1;
                                    o_cmd.cmd_kind      = pkbu_pkg::CMD_SETTING;
                                    o_cmd.setting_id    = r_set_id;
                                    o_cmd.setting_value = word;
                                end
                            end
                            default: begin
                                o_fire = 1'b0;
                            end
                        endcase
                    end
                end
            end
        end
        if (i_take && i_last_of_packet) begin
            n_mode   = pkbu_pkg::MODE_FILL;
            n_held   = '0;
            n_bytes  = '0;
            n_items  = '0;
            n_set_id = '0;
            n_set_ok = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= pkbu_pkg::MODE_FILL;
            r_held   <= '0;
            r_bytes  <= '0;
            r_items  <= '0;
            r_set_id <= '0;
            r_set_ok <= 1'b0;
        end else begin
            r_mode   <= n_mode;
            r_held   <= n_held;
            r_bytes  <= n_bytes;
            r_items  <= n_items;
            r_set_id <= n_set_id;
            r_set_ok <= n_set_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
    end

    a_held_below_need: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == pkbu_pkg::MODE_FILL && r_held < pkbu_pkg::HELD_W'(pkbu_pkg::REC_BITS)) ||
        (r_mode != pkbu_pkg::MODE_FILL && r_held < pkbu_pkg::HELD_W'(pkbu_pkg::WORD_BITS)))
        else $error("accumulator holds a whole item after a byte");

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_take && i_last_of_packet |=> r_bytes == '0 && r_held == '0 && r_items == '0)
        else $error("parser not cleared after last byte of packet");

    a_bytes_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bytes <= BS_MAX)
        else $error("byte count beyond packet limit");

endmodule

@@ design/led_packet_bit_unpacker_unit.sv @@
// top level of the led packet bit unpacker: handshakes, led count register, result register
//
// Usage:
//   i_pkt carries packet bytes (packet_byte, last_of_packet) with valid/ready.
//   o_cmd carries led commands built from items that complete a record or word:
//   range fill, effect word or setting command; unused fields read as zero.
//   i_cfg_wr_en / i_cfg_wr_data write the led count (fill end is clamped
//   to led count minus one); write it only while no item is in flight.
//   One byte is taken per cycle while i_pkt.ready is high. A command appears on o_cmd
//   in the cycle after the byte that completes it is taken, held in the result register.
//   Parsing of a byte is done by the parser between the input handshake and
//   that register, so throughput is one byte per clock while o_cmd is taken.
//   Bytes that give no command leave the command in the result register untouched.
//   If the receiver stalls with a command waiting, i_pkt.ready drops until
//   that command is taken; nothing is lost or repeated.
//   Reset (synchronous, active low) sets the led count to 877, empties the
//   result register and clears the parser to the start of a packet.
module led_packet_bit_unpacker_unit #(
    parameter int MAX_PACKET_BYTES = 512
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [pkbu_pkg::LED_W-1:0]    i_cfg_wr_data,
    pkbu_in_if.sink                       i_pkt,
    pkbu_out_if.source                    o_cmd
);

    logic [pkbu_pkg::LED_W-1:0] r_led_count;
    logic                       r_out_valid, n_out_valid;
    pkbu_pkg::t_cmd             r_cmd;
    pkbu_pkg::t_cmd             cmd;
    logic                       take;
    logic                       fire;

    assign i_pkt.ready = !r_out_valid || o_cmd.ready;
    assign take        = i_pkt.valid && i_pkt.ready;

    pkbu_parser #(
        .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
    ) u_parser (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_take           (take),
        .i_packet_byte    (i_pkt.packet_byte),
        .i_last_of_packet (i_pkt.last_of_packet),
        .i_led_count      (r_led_count),
        .o_fire           (fire),
        .o_cmd            (cmd)
    );

    assign n_out_valid = (r_out_valid && !o_cmd.ready) || (take && fire);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_led_count <= pkbu_pkg::LED_COUNT_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            if (i_cfg_wr_en) begin
                r_led_count <= i_cfg_wr_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && fire) begin
            r_cmd <= cmd;
        end
    end

    assign o_cmd.valid         = r_out_valid;
    assign o_cmd.cmd_kind      = r_cmd.cmd_kind;
    assign o_cmd.range_start   = r_cmd.range_start;
    assign o_cmd.range_end     = r_cmd.range_end;
    assign o_cmd.red           = r_cmd.red;
    assign o_cmd.green         = r_cmd.green;
    assign o_cmd.blue          = r_cmd.blue;
    assign o_cmd.word_index    = r_cmd.word_index;
    assign o_cmd.word_value    = r_cmd.word_value;
    assign o_cmd.setting_id    = r_cmd.setting_id;
    assign o_cmd.setting_value = r_cmd.setting_value;

    a_fill_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_cmd.cmd_kind == pkbu_pkg::CMD_FILL |->
            r_cmd.range_start <= r_cmd.range_end && r_cmd.range_end < r_led_count)
        else $error("fill command with empty or unclamped range");

    a_setting_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_cmd.cmd_kind == pkbu_pkg::CMD_SETTING |->
            r_cmd.setting_id <= pkbu_pkg::SET_ID_MAX && r_cmd.range_end == '0)
        else $error("setting command with bad id or stray fields");

    a_word_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_cmd.cmd_kind == pkbu_pkg::CMD_WORD |->
            r_cmd.range_start == '0 && r_cmd.setting_value == '0)
        else $error("effect word carries fields of another kind");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !o_cmd.ready |=> r_out_valid && $stable(r_cmd))
        else $error("waiting command overwritten");

endmodule
